// File: design/bbw_pkg.sv
package bbw_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int BAR_W      = 6;
    localparam int CNT_W      = 12;
    localparam int RATIO_W    = 16;
    localparam int Q_FRAC     = 8;
    localparam int THR_W      = BAR_W + 1;
    localparam int PROD_W     = CNT_W + BAR_W;
    localparam int CMP_W      = CNT_W + RATIO_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Q8   = 2'd3;

    // Register reset values
    localparam logic [PIX_W-1:0]   DARK_LEVEL_RST = 8'd128;
    localparam logic [BAR_W-1:0]   MIN_BAR_RST    = 6'd4;
    localparam logic [BAR_W-1:0]   MAX_BAR_RST    = 6'd12;
    localparam logic [RATIO_W-1:0] RATIO_Q8_RST   = 16'd384;

    typedef struct packed {
        logic [PIX_W-1:0]   dark_level;
        logic [BAR_W-1:0]   min_bar;
        logic [BAR_W-1:0]   max_bar;
        logic [RATIO_W-1:0] ratio_q8;
    } cfg_t;

    // Segment events of one item, from the run coder to the lanes
    typedef struct packed {
        logic             vld;
        logic             a_vld;
        logic [CNT_W-1:0] a_len;
        logic             row_end;
        logic [CNT_W-1:0] b_len;
        logic             set_end;
    } seg_ev_t;

    // One lane's row result, also a node of the reduction tree
    typedef struct packed {
        logic             act;
        logic [CNT_W-1:0] cnt;
        logic [BAR_W-1:0] peak;
    } node_t;

    typedef struct packed {
        logic vld;
        logic set_end;
    } row_tag_t;

endpackage

// File: design/barcode_bar_width_estimator.sv
// Bar width estimator for barcode scan rows.
// Input channel (s_valid/s_ready): one grey pixel per item, left to right,
// with s_row_end on the last pixel of a row and s_set_end on the last row
// of a scan set. Result channel (m_valid/m_ready): one item per row end,
// giving the row's best segment count and bar width, the best width of the
// set so far, and m_set_done on the row that closes the set.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 dark
// level, 1 min_bar, 2 max_bar, 3 ratio_q8; always ready, write while idle.
// Throughput: one pixel per cycle while s_ready is high. From the row-end
// pixel to its result on m_valid, a row passes the input register, run
// coder, lane update and final-run update, then each level of the lane
// reduction tree and the result queue.
// Reset (aresetn, synchronous) restores the register defaults and clears
// the run, all lanes, the set best and the result queue.
// A stalled receiver only holds up the pipeline once the two-entry result
// queue is full and another row result reaches it; pixels keep flowing
// while results wait.
module barcode_bar_width_estimator #(
    parameter int ROW_PIXELS = 2048,
    parameter int LANES      = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbw_pkg::PIX_W-1:0]      s_pixel,
    input  logic                           s_row_end,
    input  logic                           s_set_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbw_pkg::CNT_W-1:0]      m_row_bar_count,
    output logic [bbw_pkg::BAR_W-1:0]      m_row_bar_width,
    output logic [bbw_pkg::BAR_W-1:0]      m_set_bar_width,
    output logic                           m_set_done,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bbw_pkg::*;

    localparam int CNT_CAP = (ROW_PIXELS < 4095) ? ROW_PIXELS : 4095;

    cfg_t     cfg_reg;
    logic     en;
    logic     out_full;
    seg_ev_t  ev;
    node_t    snap [LANES];
    row_tag_t snap_tag;
    node_t    root;
    row_tag_t root_tag;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dark_level <= DARK_LEVEL_RST;
            cfg_reg.min_bar    <= MIN_BAR_RST;
            cfg_reg.max_bar    <= MAX_BAR_RST;
            cfg_reg.ratio_q8   <= RATIO_Q8_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DARK_LEVEL: cfg_reg.dark_level <= cfg_data[PIX_W-1:0];
                CFG_MIN_BAR:    cfg_reg.min_bar    <= cfg_data[BAR_W-1:0];
                CFG_MAX_BAR:    cfg_reg.max_bar    <= cfg_data[BAR_W-1:0];
                CFG_RATIO_Q8:   cfg_reg.ratio_q8   <= cfg_data[RATIO_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Stall the whole pipeline only when a row result meets a full queue
    assign en      = !(root_tag.vld && out_full);
    assign s_ready = en;

    bbw_run #(
        .CNT_CAP (CNT_CAP)
    ) u_run (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_valid   (s_valid),
        .s_pixel   (s_pixel),
        .s_row_end (s_row_end),
        .s_set_end (s_set_end),
        .cfg       (cfg_reg),
        .ev        (ev)
    );

    bbw_lanes #(
        .LANES   (LANES),
        .CNT_CAP (CNT_CAP)
    ) u_lanes (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_reg),
        .ev       (ev),
        .snap     (snap),
        .snap_tag (snap_tag)
    );

    bbw_reduce #(
        .LANES (LANES)
    ) u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .leaf     (snap),
        .leaf_tag (snap_tag),
        .root     (root),
        .root_tag (root_tag)
    );

    bbw_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (root_tag.vld && en),
        .row             (root),
        .row_set_end     (root_tag.set_end),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_row_bar_count (m_row_bar_count),
        .m_row_bar_width (m_row_bar_width),
        .m_set_bar_width (m_set_bar_width),
        .m_set_done      (m_set_done),
        .full            (out_full)
    );

endmodule

// File: design/bbw_run.sv
module bbw_run #(
    parameter int CNT_CAP = 2048
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       s_valid,
    input  logic [bbw_pkg::PIX_W-1:0]  s_pixel,
    input  logic                       s_row_end,
    input  logic                       s_set_end,
    input  bbw_pkg::cfg_t              cfg,
    output bbw_pkg::seg_ev_t           ev
);
    import bbw_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

    logic             in_vld_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             row_end_reg;
    logic             set_end_reg;

    logic             started_reg, started_next;
    logic             colour_reg, colour_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] len_inc;
    logic             dark;
    seg_ev_t          ev_reg, ev_next;

    // Input register: take an item whenever the pipeline advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg     <= s_pixel;
            row_end_reg <= s_row_end;
            set_end_reg <= s_set_end;
        end
    end

    assign dark    = pix_reg <= cfg.dark_level;
    assign len_inc = (len_reg >= CAP) ? len_reg : len_reg + 1'b1;

    // Run-length code the row: close a dark run on a light pixel, close the
    // final run at row end
    always_comb begin
        started_next  = started_reg;
        colour_next   = colour_reg;
        len_next      = len_reg;
        ev_next       = '0;
        ev_next.vld   = in_vld_reg;
        ev_next.a_len = len_reg;
        ev_next.set_end = set_end_reg;
        if (in_vld_reg) begin
            if (!started_reg) begin
                started_next = 1'b1;
                colour_next  = dark;
                len_next     = {{(CNT_W-1){1'b0}}, 1'b1};
            end else if (dark == colour_reg) begin
                len_next = len_inc;
            end else begin
                ev_next.a_vld = colour_reg;
                colour_next   = dark;
                len_next      = {{(CNT_W-1){1'b0}}, 1'b1};
            end
            ev_next.b_len   = len_next;
            ev_next.row_end = row_end_reg;
            if (row_end_reg) begin
                started_next = 1'b0;
                colour_next  = 1'b0;
                len_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            colour_reg  <= 1'b0;
            len_reg     <= '0;
            ev_reg      <= '0;
        end else if (en) begin
            started_reg <= started_next;
            colour_reg  <= colour_next;
            len_reg     <= len_next;
            ev_reg      <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

// File: design/bbw_lanes.sv
module bbw_lanes #(
    parameter int LANES   = 16,
    parameter int CNT_CAP = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  bbw_pkg::cfg_t      cfg,
    input  bbw_pkg::seg_ev_t   ev,
    output bbw_pkg::node_t     snap [LANES],
    output bbw_pkg::row_tag_t  snap_tag
);
    import bbw_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

    // The final run of a row is fed from b_pend_reg, registered from the row-end item
    logic             b_pend_reg;
    logic [CNT_W-1:0] b_len_reg;
    logic             b_set_reg;
    row_tag_t         snap_tag_reg;

    logic             feed;
    logic [CNT_W-1:0] seg;

    assign feed = b_pend_reg || (ev.vld && ev.a_vld);
    assign seg  = b_pend_reg ? b_len_reg : ev.a_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_pend_reg   <= 1'b0;
            snap_tag_reg <= '0;
        end else if (en) begin
            b_pend_reg   <= ev.vld && ev.row_end;
            snap_tag_reg <= '{vld: b_pend_reg, set_end: b_set_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_len_reg <= ev.b_len;
            b_set_reg <= ev.set_end;
        end
    end

    assign snap_tag = snap_tag_reg;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic             locked_reg, locked_next;
        logic [CNT_W-1:0] ocnt_reg, ocnt_next;
        logic [CNT_W-1:0] osum_reg, osum_next;
        logic [BAR_W-1:0] opeak_reg, opeak_next;
        logic [CNT_W-1:0] bcnt_reg, bcnt_next;
        logic [BAR_W-1:0] bpeak_reg, bpeak_next;
        node_t            snap_reg;
        logic [THR_W-1:0] thr;
        logic             act;
        logic             fits;
        logic             accept;
        logic [PROD_W-1:0] pk_prod;
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        logic [CNT_W:0]   cnt_inc;
        logic [CNT_W:0]   sum_add;

        // Lane zero runs at max_bar, the rest step up from min_bar
        if (k == 0) begin : g_first
            assign thr = {1'b0, cfg.max_bar};
            assign act = 1'b1;
        end else begin : g_rest
            assign thr = {1'b0, cfg.min_bar} + THR_W'(k - 1);
            assign act = thr < {1'b0, cfg.max_bar};
        end

        assign fits = seg <= {{(CNT_W-THR_W){1'b0}}, thr};

        // Accept when peak * count < sum * ratio (Q8.8)
        assign pk_prod = ocnt_reg * opeak_reg;
        assign lhs     = {{(CMP_W-PROD_W-Q_FRAC){1'b0}}, pk_prod, {Q_FRAC{1'b0}}};
        assign rhs     = osum_reg * cfg.ratio_q8;
        assign accept  = lhs < rhs;

        assign cnt_inc = {1'b0, ocnt_reg} + 1'b1;
        assign sum_add = {1'b0, osum_reg} + {1'b0, seg};

        // Open, extend or close the lane's string
        always_comb begin
            locked_next = locked_reg;
            ocnt_next   = ocnt_reg;
            osum_next   = osum_reg;
            opeak_next  = opeak_reg;
            bcnt_next   = bcnt_reg;
            bpeak_next  = bpeak_reg;
            if (feed && act) begin
                if (locked_reg) begin
                    if (!fits) begin
                        locked_next = 1'b0;
                        if (ocnt_reg > bcnt_reg && accept) begin
                            bcnt_next  = ocnt_reg;
                            bpeak_next = opeak_reg;
                        end
                    end else begin
                        ocnt_next = (cnt_inc > {1'b0, CAP}) ? CAP : cnt_inc[CNT_W-1:0];
                        osum_next = (sum_add > {1'b0, CAP}) ? CAP : sum_add[CNT_W-1:0];
                        if (seg > {{(CNT_W-BAR_W){1'b0}}, opeak_reg}) begin
                            opeak_next = seg[BAR_W-1:0];
                        end
                    end
                end else if (fits) begin
                    locked_next = 1'b1;
                    ocnt_next   = {{(CNT_W-1){1'b0}}, 1'b1};
                    osum_next   = seg;
                    opeak_next  = seg[BAR_W-1:0];
                end
            end
        end

        // Advance the lane, clear it after the row's last segment
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                locked_reg <= 1'b0;
                ocnt_reg   <= '0;
                osum_reg   <= '0;
                opeak_reg  <= '0;
                bcnt_reg   <= '0;
                bpeak_reg  <= '0;
            end else if (en) begin
                if (b_pend_reg) begin
                    locked_reg <= 1'b0;
                    ocnt_reg   <= '0;
                    osum_reg   <= '0;
                    opeak_reg  <= '0;
                    bcnt_reg   <= '0;
                    bpeak_reg  <= '0;
                end else begin
                    locked_reg <= locked_next;
                    ocnt_reg   <= ocnt_next;
                    osum_reg   <= osum_next;
                    opeak_reg  <= opeak_next;
                    bcnt_reg   <= bcnt_next;
                    bpeak_reg  <= bpeak_next;
                end
            end
        end

        // Hold the lane's row best for the reduction
        always_ff @(posedge aclk) begin
            if (en) begin
                snap_reg <= '{act: act, cnt: bcnt_next, peak: bpeak_next};
            end
        end

        assign snap[k] = snap_reg;
    end

endmodule

// File: design/bbw_reduce.sv
module bbw_reduce #(
    parameter int LANES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  bbw_pkg::node_t     leaf [LANES],
    input  bbw_pkg::row_tag_t  leaf_tag,
    output bbw_pkg::node_t     root,
    output bbw_pkg::row_tag_t  root_tag
);
    import bbw_pkg::*;

    localparam int LVLS  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int P     = 1 << LVLS;
    localparam int NODES = P - 1;

    node_t    node_reg  [NODES];
    node_t    node_next [NODES];
    node_t    all_node  [2*P-1];
    row_tag_t tag_reg   [LVLS];

    // Higher lane wins a tie; inactive lanes never win
    function automatic node_t pick_node(input node_t l, input node_t r);
        node_t res;
        res = l;
        if (r.act && (!l.act || r.cnt >= l.cnt)) begin
            res = r;
        end
        return res;
    endfunction

    // Heap layout: internal nodes first, lanes as leaves in order
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            all_node[i] = node_reg[i];
        end
        for (int i = 0; i < P; i++) begin
            all_node[NODES + i] = (i < LANES) ? leaf[i] : '0;
        end
        for (int i = 0; i < NODES; i++) begin
            node_next[i] = pick_node(all_node[2*i+1], all_node[2*i+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NODES; i++) begin
                node_reg[i] <= node_next[i];
            end
        end
    end

    // Carry the row tag alongside each tree level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LVLS; l++) begin
                tag_reg[l] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= leaf_tag;
            for (int l = 1; l < LVLS; l++) begin
                tag_reg[l] <= tag_reg[l-1];
            end
        end
    end

    assign root     = all_node[0];
    assign root_tag = tag_reg[LVLS-1];

endmodule

// File: design/bbw_out.sv
module bbw_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  bbw_pkg::node_t             row,
    input  logic                       row_set_end,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [bbw_pkg::CNT_W-1:0]  m_row_bar_count,
    output logic [bbw_pkg::BAR_W-1:0]  m_row_bar_width,
    output logic [bbw_pkg::BAR_W-1:0]  m_set_bar_width,
    output logic                       m_set_done,
    output logic                       full
);
    import bbw_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0] row_cnt;
        logic [BAR_W-1:0] row_w;
        logic [BAR_W-1:0] set_w;
        logic             set_done;
    } res_t;

    localparam logic [1:0] OUT_FULL = 2'd2;

    logic [CNT_W-1:0] set_cnt_reg;
    logic [BAR_W-1:0] set_w_reg;
    logic             take;
    res_t             res;

    res_t             fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    // A newer row replaces the set best unless the best is strictly longer
    assign take         = !(set_cnt_reg > row.cnt);
    assign res.row_cnt  = row.cnt;
    assign res.row_w    = row.peak;
    assign res.set_w    = take ? row.peak : set_w_reg;
    assign res.set_done = row_set_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_cnt_reg <= '0;
            set_w_reg   <= '0;
        end else if (push) begin
            if (row_set_end) begin
                set_cnt_reg <= '0;
                set_w_reg   <= '0;
            end else if (take) begin
                set_cnt_reg <= row.cnt;
                set_w_reg   <= row.peak;
            end
        end
    end

    // Two-entry result queue
    assign pop  = m_valid && m_ready;
    assign full = cnt_reg == OUT_FULL;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign m_valid         = cnt_reg != 2'd0;
    assign m_row_bar_count = fifo_reg[rd_ptr_reg].row_cnt;
    assign m_row_bar_width = fifo_reg[rd_ptr_reg].row_w;
    assign m_set_bar_width = fifo_reg[rd_ptr_reg].set_w;
    assign m_set_done      = fifo_reg[rd_ptr_reg].set_done;

endmodule

// File: design/bbw_chk.sv
module bbw_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [bbw_pkg::CNT_W-1:0]      m_row_bar_count,
    input logic [bbw_pkg::BAR_W-1:0]      m_row_bar_width,
    input logic [bbw_pkg::BAR_W-1:0]      m_set_bar_width,
    input logic                           m_set_done
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_bar_count)
            && $stable(m_row_bar_width) && $stable(m_set_bar_width)
            && $stable(m_set_done))
        else $error("result item changed while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A row with no accepted string has no width
    a_empty_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_bar_count == 0 |-> m_row_bar_width == 0)
        else $error("zero count with nonzero width");

    // An accepted string has a width, and so does the set best
    a_found_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_bar_count != 0 |-> m_row_bar_width != 0
            && m_set_bar_width != 0)
        else $error("nonzero count with zero width");

endmodule

bind barcode_bar_width_estimator bbw_chk u_chk (.*);
